// ----- design/pkt_pkg.sv -----
// Shared types, constants and slot functions for the pedigree kinship table.
// Used by pedigree_kinship_table; depends on nothing else.
package pkt_pkg;

  localparam int MAX_MEMBERS  = 32;
  localparam int FRAC_BITS    = 32;
  localparam int IDX_W        = 5;
  localparam int COEF_W       = 33;
  localparam int CNT_W        = $clog2(MAX_MEMBERS + 1);
  localparam int PAIR_DEPTH   = MAX_MEMBERS * (MAX_MEMBERS + 1) / 2;
  localparam int TRIPLE_DEPTH = MAX_MEMBERS * (MAX_MEMBERS + 1) * (MAX_MEMBERS + 2) / 6;
  localparam int PAIR_AW      = $clog2(PAIR_DEPTH);
  localparam int TRIPLE_AW    = $clog2(TRIPLE_DEPTH);
  localparam int PAR_W        = 2 * IDX_W + 1;

  localparam logic [COEF_W-1:0] KIN_ONE     = COEF_W'(1) << FRAC_BITS;
  localparam logic [COEF_W-1:0] KIN_HALF    = KIN_ONE >> 1;
  localparam logic [COEF_W-1:0] KIN_QUARTER = KIN_ONE >> 2;

  typedef enum logic [1:0] {
    OP_NEW     = 2'd0,
    OP_ADD     = 2'd1,
    OP_QPAIR   = 2'd2,
    OP_QTRIPLE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_PARENT = 2'd2,
    ST_INDEX  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    F_CONST = 2'd0,
    F_HALF  = 2'd1,
    F_QUART = 2'd2,
    F_AVG   = 2'd3
  } formula_t;

  // one parent table row
  typedef struct packed {
    logic             hp;
    logic [IDX_W-1:0] p1;
    logic [IDX_W-1:0] p2;
  } par_t;

  // one store read: pair (x, y) or triple (x, y, z)
  typedef struct packed {
    logic             trip;
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [IDX_W-1:0] z;
  } oper_t;

  // how one coefficient is formed
  typedef struct packed {
    formula_t          form;
    logic [COEF_W-1:0] cval;
    oper_t             k0;
    oper_t             k1;
  } plan_t;

  typedef logic [MAX_MEMBERS-1:0][PAIR_AW-1:0]   tri_tab_t;
  typedef logic [MAX_MEMBERS-1:0][TRIPLE_AW-1:0] tet_tab_t;

  function automatic tri_tab_t build_tri();
    tri_tab_t t;
    for (int i = 0; i < MAX_MEMBERS; i++) t[i] = PAIR_AW'(i * (i + 1) / 2);
    return t;
  endfunction

  function automatic tet_tab_t build_tet();
    tet_tab_t t;
    for (int i = 0; i < MAX_MEMBERS; i++) t[i] = TRIPLE_AW'(i * (i + 1) * (i + 2) / 6);
    return t;
  endfunction

  localparam tri_tab_t TRI_TABLE = build_tri();
  localparam tet_tab_t TET_TABLE = build_tet();

  // packed lower-triangle slot of an unordered pair
  function automatic logic [PAIR_AW-1:0] pair_slot(input logic [IDX_W-1:0] x,
                                                   input logic [IDX_W-1:0] y);
    logic [IDX_W-1:0] hi, lo;
    hi = (y > x) ? y : x;
    lo = (y > x) ? x : y;
    return TRI_TABLE[hi] + PAIR_AW'(lo);
  endfunction

  // slot of an unordered triple, sorted descending first
  function automatic logic [TRIPLE_AW-1:0] triple_slot(input logic [IDX_W-1:0] x,
                                                       input logic [IDX_W-1:0] y,
                                                       input logic [IDX_W-1:0] z);
    logic [IDX_W-1:0] a, b, c, t;
    a = x; b = y; c = z;
    if (b > a) begin t = a; a = b; b = t; end
    if (c > b) begin t = b; b = c; c = t; end
    if (b > a) begin t = a; a = b; b = t; end
    return TET_TABLE[a] + TRIPLE_AW'(TRI_TABLE[b]) + TRIPLE_AW'(c);
  endfunction

  // youngest parent plus one, 0 for a founder
  function automatic logic [IDX_W:0] youngest(input par_t p);
    logic [IDX_W-1:0] m;
    m = (p.p1 > p.p2) ? p.p1 : p.p2;
    return p.hp ? ({1'b0, m} + 1'b1) : '0;
  endfunction

endpackage

// ----- design/pkt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module pkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/pedigree_kinship_table.sv -----
// Pedigree kinship table: sequencer, parent table and pair/triple coefficient stores.
// Depends on pkt_pkg and pkt_ram.
//
//   channel | handshake                  | beat contents
//   item    | item_valid / item_stall    | opcode, has_parents, first_parent, second_parent,
//           |                            | index_a, index_b, index_c
//   result  | result_valid / result_stall| coefficient, status, assigned_index
//
// Start and errors go straight to the result; a query makes one registered store read.
// Adding member a writes (a+1) pair entries and (a+1)(a+2)/2 triple entries; each entry takes two
// parent reads, a plan step, two store reads and a write through the shared adders.
// Reset is synchronous and clears the count and control only; stores need no clearing.
// item_stall is high while an item is being worked; a waiting result does not block
// the next item.
module pedigree_kinship_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                opcode,
  input  logic                      has_parents,
  input  logic [pkt_pkg::IDX_W-1:0] first_parent,
  input  logic [pkt_pkg::IDX_W-1:0] second_parent,
  input  logic [pkt_pkg::IDX_W-1:0] index_a,
  input  logic [pkt_pkg::IDX_W-1:0] index_b,
  input  logic [pkt_pkg::IDX_W-1:0] index_c,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [pkt_pkg::COEF_W-1:0] coefficient,
  output logic [1:0]                status,
  output logic [pkt_pkg::IDX_W-1:0] assigned_index
);

  import pkt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDB, S_RDC, S_PLAN, S_RD0, S_RD1, S_CALC, S_QRD, S_QCAP, S_DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  fill_count;
  logic [IDX_W-1:0]  cur_a, lb, lc;
  logic              tri_phase;
  par_t              par_a, par_b, par_c;
  plan_t             plan, plan_next;
  logic [COEF_W-1:0] r0, rd1, calc_val;
  logic [COEF_W-1:0] pend_coef;
  status_t           pend_status;
  logic [IDX_W-1:0]  pend_assigned;

  logic              par_we;
  logic [IDX_W-1:0]  par_raddr;
  logic [PAR_W-1:0]  par_rdata;
  logic              add_full, add_bad, idx_bad2, idx_bad3;
  oper_t             opnd;
  logic              pair_we, trip_we;
  logic [COEF_W-1:0] pair_rdata, trip_rdata;
  logic [COEF_W:0]   sum_avg, sum_half;
  logic [COEF_W+2:0] sum_quart;

  assign item_stall = (state != S_IDLE);

  // check an add and a query against the loaded count
  assign add_full = (fill_count == CNT_W'(MAX_MEMBERS));
  assign add_bad  = has_parents && (({1'b0, first_parent} >= fill_count) ||
                                    ({1'b0, second_parent} >= fill_count));
  assign idx_bad2 = ({1'b0, index_a} >= fill_count) || ({1'b0, index_b} >= fill_count);
  assign idx_bad3 = idx_bad2 || ({1'b0, index_c} >= fill_count);

  // parent table: written on a good add, read for b then c
  assign par_we    = (state == S_IDLE) && item_valid && (opcode_t'(opcode) == OP_ADD) &&
                     !add_full && !add_bad;
  assign par_raddr = (state == S_RDB) ? lb : lc;

  pkt_ram #(.WIDTH(PAR_W), .DEPTH(MAX_MEMBERS)) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (fill_count[IDX_W-1:0]),
    .wdata (has_parents ? {1'b1, first_parent, second_parent} : PAR_W'(0)),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  // coefficient stores, both read at the current operand
  assign opnd    = (state == S_RD1) ? plan.k1 : plan.k0;
  assign pair_we = (state == S_CALC) && !tri_phase;
  assign trip_we = (state == S_CALC) && tri_phase;

  pkt_ram #(.WIDTH(COEF_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_slot(cur_a, lb)),
    .wdata (calc_val),
    .raddr (pair_slot(opnd.x, opnd.y)),
    .rdata (pair_rdata)
  );

  pkt_ram #(.WIDTH(COEF_W), .DEPTH(TRIPLE_DEPTH)) u_trip_ram (
    .clk   (clk),
    .we    (trip_we),
    .waddr (triple_slot(cur_a, lb, lc)),
    .wdata (calc_val),
    .raddr (triple_slot(opnd.x, opnd.y, opnd.z)),
    .rdata (trip_rdata)
  );

  function automatic oper_t pr(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y);
    return '{trip: 1'b0, x: x, y: y, z: '0};
  endfunction

  function automatic oper_t tr(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
                               input logic [IDX_W-1:0] z);
    return '{trip: 1'b1, x: x, y: y, z: z};
  endfunction

  // kinship of x twice with y, descending through the younger line
  function automatic plan_t dbl_single(input logic [IDX_W-1:0] x, input par_t px,
                                       input logic [IDX_W-1:0] y, input par_t py);
    plan_t p;
    p.form = F_AVG;
    p.cval = '0;
    if (youngest(px) >= youngest(py)) begin
      p.k0 = pr(x, y);
      p.k1 = tr(px.p1, px.p2, y);
    end else begin
      p.k0 = pr(y, x);
      p.k1 = tr(py.p1, py.p2, x);
    end
    return p;
  endfunction

  // plan the entry from the three parent rows
  always_comb begin
    logic [IDX_W:0] ya, yb, yc;
    par_c = par_t'(par_rdata);
    ya = youngest(par_a);
    yb = youngest(par_b);
    yc = youngest(par_c);
    plan_next = '{form: F_CONST, cval: '0, k0: '0, k1: '0};
    if (!tri_phase) begin
      if (!par_a.hp && !par_b.hp) begin
        plan_next.cval = (cur_a == lb) ? KIN_HALF : '0;
      end else if (cur_a == lb) begin
        plan_next.form = F_HALF;
        plan_next.k0   = pr(par_a.p1, par_a.p2);
      end else if (ya >= yb) begin
        plan_next.form = F_AVG;
        plan_next.k0   = pr(par_a.p1, lb);
        plan_next.k1   = pr(par_a.p2, lb);
      end else begin
        plan_next.form = F_AVG;
        plan_next.k0   = pr(par_b.p1, cur_a);
        plan_next.k1   = pr(par_b.p2, cur_a);
      end
    end else begin
      if (!par_a.hp && !par_b.hp && !par_c.hp) begin
        plan_next.cval = ((cur_a == lb) && (lb == lc)) ? KIN_QUARTER : '0;
      end else if ((cur_a == lb) && (lb == lc)) begin
        plan_next.form = F_QUART;
        plan_next.k0   = pr(par_a.p1, par_a.p2);
      end else if (cur_a == lb) begin
        plan_next = dbl_single(cur_a, par_a, lc, par_c);
      end else if (lb == lc) begin
        plan_next = dbl_single(cur_a, par_a, lb, par_b);
      end else if ((ya >= yb) && (ya >= yc)) begin
        plan_next.form = F_AVG;
        plan_next.k0   = tr(par_a.p1, lb, lc);
        plan_next.k1   = tr(par_a.p2, lb, lc);
      end else if ((yb >= ya) && (yb >= yc)) begin
        plan_next.form = F_AVG;
        plan_next.k0   = tr(par_b.p1, cur_a, lc);
        plan_next.k1   = tr(par_b.p2, cur_a, lc);
      end else begin
        plan_next.form = F_AVG;
        plan_next.k0   = tr(par_c.p1, cur_a, lb);
        plan_next.k1   = tr(par_c.p2, cur_a, lb);
      end
    end
  end

  // shared adders: halve or quarter, truncating
  assign rd1       = plan.k1.trip ? trip_rdata : pair_rdata;
  assign sum_avg   = {1'b0, r0} + {1'b0, rd1};
  assign sum_half  = {1'b0, KIN_ONE} + {1'b0, r0};
  assign sum_quart = {3'b0, KIN_ONE} + {3'b0, r0} + {2'b0, r0, 1'b0};

  always_comb begin
    case (plan.form)
      F_HALF:  calc_val = sum_half[COEF_W:1];
      F_QUART: calc_val = sum_quart[COEF_W+1:2];
      F_AVG:   calc_val = sum_avg[COEF_W:1];
      default: calc_val = plan.cval;
    endcase
  end

  // sequencer, loop indices and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            pend_coef     <= '0;
            pend_assigned <= '0;
            case (opcode_t'(opcode))
              OP_NEW: begin
                fill_count  <= '0;
                pend_status <= ST_OK;
                state       <= S_DONE;
              end
              OP_ADD: begin
                if (add_full) begin
                  pend_status <= ST_FULL;
                  state       <= S_DONE;
                end else if (add_bad) begin
                  pend_status <= ST_PARENT;
                  state       <= S_DONE;
                end else begin
                  pend_status <= ST_OK;
                  par_a     <= has_parents ? par_t'{hp: 1'b1, p1: first_parent,
                                                    p2: second_parent}
                                           : par_t'('0);
                  cur_a     <= fill_count[IDX_W-1:0];
                  lb        <= '0;
                  lc        <= '0;
                  tri_phase <= 1'b0;
                  state     <= S_RDB;
                end
              end
              OP_QPAIR: begin
                if (idx_bad2) begin
                  pend_status <= ST_INDEX;
                  state       <= S_DONE;
                end else begin
                  pend_status <= ST_OK;
                  plan.k0     <= pr(index_a, index_b);
                  state       <= S_QRD;
                end
              end
              OP_QTRIPLE: begin
                if (idx_bad3) begin
                  pend_status <= ST_INDEX;
                  state       <= S_DONE;
                end else begin
                  pend_status <= ST_OK;
                  plan.k0     <= tr(index_a, index_b, index_c);
                  state       <= S_QRD;
                end
              end
              default: begin
                pend_status <= ST_OK;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_RDB: state <= S_RDC;
        S_RDC: begin
          par_b <= par_t'(par_rdata);
          state <= S_PLAN;
        end
        S_PLAN: begin
          plan  <= plan_next;
          state <= S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          r0    <= plan.k0.trip ? trip_rdata : pair_rdata;
          state <= S_CALC;
        end
        S_CALC: begin
          if (!tri_phase) begin
            state <= S_RDB;
            if (lb == cur_a) begin
              tri_phase <= 1'b1;
              lb        <= '0;
              lc        <= '0;
            end else begin
              lb <= lb + 1'b1;
            end
          end else if (lc == lb) begin
            if (lb == cur_a) begin
              fill_count    <= fill_count + 1'b1;
              pend_assigned <= cur_a;
              state         <= S_DONE;
            end else begin
              lb    <= lb + 1'b1;
              lc    <= '0;
              state <= S_RDB;
            end
          end else begin
            lc    <= lc + 1'b1;
            state <= S_RDB;
          end
        end
        S_QRD: state <= S_QCAP;
        S_QCAP: begin
          pend_coef <= plan.k0.trip ? trip_rdata : pair_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            coefficient    <= pend_coef;
            status         <= pend_status;
            assigned_index <= pend_assigned;
            result_valid   <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_MEMBERS))
    else $error("member count beyond capacity");

  a_loop_order: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DONE && state != S_QRD && state != S_QCAP)
      |-> (lc <= lb && lb <= cur_a))
    else $error("entry loop left the lower triangle");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && tri_phase && lc == lb && lb == cur_a)
      |=> (fill_count == $past(fill_count) + 1'b1))
    else $error("finished add did not advance the count");
`endif

endmodule
